FILE: rtl/core/jbuf_pkg.sv
// Shared types and constants for the paced FIFO jitter buffer.
package jbuf_pkg;

   // Command codes carried in the request word; the no-op code does nothing
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_POP  = 2'd2,
      CMD_NOP  = 2'd3
   } jbuf_cmd_type;

   // Register indexes on the csr port
   localparam logic CSR_MIN_FILL    = 1'b0;
   localparam logic CSR_MIN_SPACING = 1'b1;

   // Fixed field widths of the channel words
   localparam int unsigned FILL_W    = 5;
   localparam int unsigned SPACING_W = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned WORD_W    = 32;
   // Widest supported storage word
   localparam int unsigned MAX_DATA_W = 64;

   typedef struct packed {
      jbuf_cmd_type        cmd;
      logic [15:0]         tick_len;
      logic [WORD_W-1:0]   payload;
   } jbuf_req_type;

   typedef struct packed {
      logic                out_valid;
      logic [WORD_W-1:0]   out_data;
      logic [FILL_W-1:0]   fill_count;
      logic                dropped;
   } jbuf_rsp_type;

endpackage

FILE: rtl/core/jbuf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jbuf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, output held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/jitter_buffer_paced_fifo.sv
// Paced FIFO jitter buffer: queue, prefill gate, pacing timer and result pipeline.
//
// Usage: each request word carries one command. TICK adds tick_len to a
// wrapping 32-bit time counter, PUSH appends payload to the queue, POP
// releases the head word once the queue has reached min_fill words and the
// pacing time (min_spacing ticks past the previous release's slot) has come.
// Every request word yields exactly one response word with the fill count;
// a push into a full queue is dropped and flagged.
// A response passes through the read stage, which waits for the queue RAM
// read, and then the response register. Throughput: one request per cycle
// while rsp_ready stays high; all state updates happen at the accept edge,
// and the RAM's read data is registered.
// Stall: when rsp_ready is low the response register holds; the stage behind
// it holds one more word, after which req_ready drops until rsp_ready rises.
// Reset clears the queue pointers, fill count, time counter, pacing mark,
// lock and both registers; queue contents are not cleared.
// Registers on the csr port: index 0 min_fill (writing it recomputes the
// lock), index 1 min_spacing (zero turns pacing off). Write only when idle.
module jitter_buffer_paced_fifo #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  jbuf_pkg::jbuf_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output jbuf_pkg::jbuf_rsp_type                rsp_data,
   input  logic                                  csr_we,
   input  logic                                  csr_addr,
   input  logic [jbuf_pkg::SPACING_W-1:0]        csr_wdata
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > jbuf_pkg::FILL_W) ? CW : jbuf_pkg::FILL_W;

   // queue and pacing state
   logic [AW-1:0]                   head_ff, head_in;
   logic [AW-1:0]                   tail_ff, tail_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [jbuf_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [jbuf_pkg::TIME_W-1:0]     next_send_ff, next_send_in;
   logic                            locked_ff, locked_in;
   logic [jbuf_pkg::FILL_W-1:0]     min_fill_ff, min_fill_in;
   logic [jbuf_pkg::SPACING_W-1:0]  min_spacing_ff, min_spacing_in;

   // read stage and response register
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_rel_ff;
   logic                            s1_drop_ff;
   logic [jbuf_pkg::FILL_W-1:0]     s1_fill_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   jbuf_pkg::jbuf_rsp_type          rsp_data_ff;

   logic                            req_fire;
   logic                            s1_move;
   logic                            release_word;
   logic                            drop_word;
   logic                            early;
   logic                            ram_we;
   logic [jbuf_pkg::MAX_DATA_W-1:0] push_wide;
   logic [jbuf_pkg::MAX_DATA_W-1:0] pop_wide;
   logic [DATA_WIDTH-1:0]           ram_rd_data;
   logic [CMPW-1:0]                 count_ext_in;

   // handshake
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   // pacing gate: plain unsigned compare, only with pacing on
   assign early = (min_spacing_ff != '0) && (next_send_ff > now_ff);

   // command decode and next state
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      now_in         = now_ff;
      next_send_in   = next_send_ff;
      locked_in      = locked_ff;
      min_fill_in    = min_fill_ff;
      min_spacing_in = min_spacing_ff;
      release_word   = 1'b0;
      drop_word      = 1'b0;
      ram_we         = 1'b0;
      if (req_fire) begin
         case (req_data.cmd)
            jbuf_pkg::CMD_TICK: begin
               now_in = now_ff + jbuf_pkg::TIME_W'(req_data.tick_len);
            end
            jbuf_pkg::CMD_PUSH: begin
               if (count_ff == CW'(DEPTH)) begin
                  drop_word = 1'b1;
               end else begin
                  ram_we   = 1'b1;
                  tail_in  = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
                  if (locked_ff && (CMPW'(count_in) >= CMPW'(min_fill_ff))) begin
                     locked_in = 1'b0;
                  end
               end
            end
            jbuf_pkg::CMD_POP: begin
               if (!locked_ff && !early && (count_ff != '0)) begin
                  release_word = 1'b1;
                  head_in      = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in     = count_ff - 1'b1;
                  if (min_spacing_ff != '0) begin
                     next_send_in = ((next_send_ff == '0) ? now_ff : next_send_ff)
                                    + jbuf_pkg::TIME_W'(min_spacing_ff);
                  end
                  // queue drained: relock and restart pacing
                  if (count_ff == CW'(1)) begin
                     locked_in    = 1'b1;
                     next_send_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // register writes; the user writes only while idle, this block does not enforce it
      if (csr_we) begin
         case (csr_addr)
            jbuf_pkg::CSR_MIN_FILL: begin
               min_fill_in = csr_wdata[jbuf_pkg::FILL_W-1:0];
               locked_in   = CMPW'(csr_wdata[jbuf_pkg::FILL_W-1:0]) > CMPW'(count_ff);
            end
            jbuf_pkg::CSR_MIN_SPACING: begin
               min_spacing_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         now_ff         <= '0;
         next_send_ff   <= '0;
         locked_ff      <= 1'b0;
         min_fill_ff    <= '0;
         min_spacing_ff <= '0;
      end else begin
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         now_ff         <= now_in;
         next_send_ff   <= next_send_in;
         locked_ff      <= locked_in;
         min_fill_ff    <= min_fill_in;
         min_spacing_ff <= min_spacing_in;
      end
   end

   // queue storage
   assign push_wide = jbuf_pkg::MAX_DATA_W'(req_data.payload);

   jbuf_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (push_wide[DATA_WIDTH-1:0]),
      .rd_en   (release_word),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign pop_wide     = jbuf_pkg::MAX_DATA_W'(ram_rd_data);
   assign count_ext_in = CMPW'(count_in);

   // read stage: result flags wait here for the RAM data
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_rel_ff  <= release_word;
         s1_drop_ff <= drop_word;
         s1_fill_ff <= count_ext_in[jbuf_pkg::FILL_W-1:0];
      end
   end

   // response register
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.out_valid  <= s1_rel_ff;
         rsp_data_ff.out_data   <= s1_rel_ff ? pop_wide[jbuf_pkg::WORD_W-1:0] : '0;
         rsp_data_ff.fill_count <= s1_fill_ff;
         rsp_data_ff.dropped    <= s1_drop_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above queue depth");

   a_empty_relocks: assert property (@(posedge clock) disable iff (reset)
      release_word && (count_ff == CW'(1)) && !csr_we |=> locked_ff && (next_send_ff == '0))
      else $error("draining release did not relock");

   a_no_word_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.out_valid |-> rsp_data_ff.out_data == '0)
      else $error("data present without a released word");

   a_drop_not_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.dropped |-> !rsp_data_ff.out_valid)
      else $error("dropped and released in one response");

   a_release_not_empty: assert property (@(posedge clock) disable iff (reset)
      release_word |-> !locked_ff && (count_ff != '0))
      else $error("release while locked or empty");

endmodule
